// ===== rtl/core/depth_min_max_tone_map_macros.svh =====
// Assertion macros for the depth tone map checker.
// Both expect aclk in the enclosing scope; DMMTM_ASSERT also expects aresetn.
`ifndef DEPTH_MIN_MAX_TONE_MAP_MACROS_SVH
`define DEPTH_MIN_MAX_TONE_MAP_MACROS_SVH

// Check outside reset.
`define DMMTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check at every edge, reset included.
`define DMMTM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/dmmtm_pkg.sv =====
package dmmtm_pkg;

    localparam int QUOT_BITS = 8;

    // 223 * x = (x << 8) - (x << 5) - x
    localparam int SPAN_HI_SHIFT  = 8;
    localparam int SPAN_MID_SHIFT = 5;

    localparam logic [QUOT_BITS-1:0] GRAY_BASE = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } div_res_t;

endpackage

// ===== rtl/core/dmmtm_range.sv =====
module dmmtm_range #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         scan_we,
    input  logic         restart,
    input  logic [W-1:0] sample,
    output logic [W-1:0] min_depth,
    output logic [W-1:0] max_depth
);

    logic [W-1:0] min_reg;
    logic [W-1:0] min_next;
    logic [W-1:0] max_reg;
    logic [W-1:0] max_next;
    logic [W-1:0] base_min;
    logic [W-1:0] base_max;

    always_comb begin
        base_min = restart ? '1 : min_reg;
        base_max = restart ? '0 : max_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (scan_we) begin
            max_next = (sample > base_max) ? sample : base_max;
            min_next = ((sample != '0) && (sample < base_min)) ? sample : base_min;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= '1;
            max_reg <= '0;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_depth = min_reg;
    assign max_depth = max_reg;

endmodule

// ===== rtl/core/dmmtm_div.sv =====
module dmmtm_div #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [W-1:0]        off,
    input  logic [W-1:0]        span,
    output dmmtm_pkg::div_res_t res
);

    localparam int QB = dmmtm_pkg::QUOT_BITS;
    localparam int NW = W + QB;
    localparam int CW = $clog2(QB);

    logic [NW-1:0] num_reg;
    logic [NW-1:0] num_next;
    logic [NW-1:0] dvs_reg;
    logic [NW-1:0] dvs_next;
    logic [QB-1:0] q_reg;
    logic [QB-1:0] q_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [NW-1:0] off_ext;
    logic [NW-1:0] prod;
    logic [NW:0]   diff;

    always_comb begin
        off_ext = NW'(off);
        prod = (off_ext << dmmtm_pkg::SPAN_HI_SHIFT)
             - (off_ext << dmmtm_pkg::SPAN_MID_SHIFT) - off_ext;
        diff = {1'b0, num_reg} - {1'b0, dvs_reg};

        num_next  = num_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            num_next  = prod;
            dvs_next  = NW'(span) << (QB - 1);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit per cycle, restoring
            if (!diff[NW]) begin
                num_next = diff[NW-1:0];
                q_next   = {q_reg[QB-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[QB-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QB - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;

endmodule

// ===== rtl/core/depth_min_max_tone_map.sv =====
// channel  | valid    | ready    | word
// ---------+----------+----------+--------------------------------------
// input    | s_valid  | s_ready  | s_mode, s_frame_start, s_depth
// result   | m_valid  | m_ready  | m_intensity, m_color_word
//
// A scan word is taken in the idle state and gives no result.
// A map word passes through operand prep, divider load, eight steps of the
// restoring divider at one quotient bit per cycle, a wait state that sees the
// divider finish, and the output load. s_ready returns with the result, so the
// next word is taken only after the map word's result is loaded.
// Synchronous active-low reset sets min to all ones, max to zero, and
// clears any pending result.
// A stalled result holds in the output register; scan words still enter,
// and a later map word waits in its last stage for the register to free.
module depth_min_max_tone_map #(
    parameter int DEPTH_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic        s_frame_start,
    input  logic [31:0] s_depth,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_intensity,
    output logic [31:0] m_color_word
);

    localparam int DW = DEPTH_BITS;

    dmmtm_pkg::state_t   state_reg;
    dmmtm_pkg::state_t   state_next;
    dmmtm_pkg::div_res_t div_res;

    logic [DW-1:0] sample;
    logic [DW-1:0] min_depth;
    logic [DW-1:0] max_depth;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] d_next;
    logic [DW-1:0] d_clamp;
    logic [DW-1:0] off_reg;
    logic [DW-1:0] off_next;
    logic [DW-1:0] span_reg;
    logic [DW-1:0] span_next;
    logic          blank_reg;
    logic          blank_next;
    logic          accept;
    logic          scan_we;
    logic          div_start;
    logic          out_load;
    logic [7:0]    gray;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [7:0]    m_intensity_reg;
    logic [7:0]    m_intensity_next;

    assign sample  = DW'(s_depth);
    assign accept  = s_valid && s_ready;
    assign scan_we = accept && !s_mode;

    dmmtm_range #(
        .W(DW)
    ) u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_we   (scan_we),
        .restart   (s_frame_start),
        .sample    (sample),
        .min_depth (min_depth),
        .max_depth (max_depth)
    );

    dmmtm_div #(
        .W(DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .off     (off_reg),
        .span    (span_reg),
        .res     (div_res)
    );

    always_comb begin
        d_clamp = (d_reg < min_depth) ? min_depth :
                  ((d_reg > max_depth) ? max_depth : d_reg);
        gray = blank_reg ? 8'd0 : (div_res.quot + dmmtm_pkg::GRAY_BASE);

        state_next       = state_reg;
        d_next           = d_reg;
        off_next         = off_reg;
        span_next        = span_reg;
        blank_next       = blank_reg;
        div_start        = 1'b0;
        out_load         = 1'b0;
        s_ready          = 1'b0;
        m_intensity_next = m_intensity_reg;

        case (state_reg)
            dmmtm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_mode) begin
                    d_next     = sample;
                    state_next = dmmtm_pkg::ST_LOAD;
                end
            end
            dmmtm_pkg::ST_LOAD: begin
                off_next   = d_clamp - min_depth;
                span_next  = max_depth - min_depth;
                blank_next = (d_reg == '0) || (max_depth <= min_depth);
                state_next = dmmtm_pkg::ST_START;
            end
            dmmtm_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = dmmtm_pkg::ST_WAIT;
            end
            dmmtm_pkg::ST_WAIT: begin
                if (div_res.done) begin
                    state_next = dmmtm_pkg::ST_DONE;
                end
            end
            dmmtm_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load         = 1'b1;
                    m_intensity_next = gray;
                    state_next       = dmmtm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmmtm_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dmmtm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg           <= d_next;
        off_reg         <= off_next;
        span_reg        <= span_next;
        blank_reg       <= blank_next;
        m_intensity_reg <= m_intensity_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_intensity  = m_intensity_reg;
    assign m_color_word = {4{m_intensity_reg}};

endmodule

// ===== rtl/core/dmmtm_checker.sv =====
`include "depth_min_max_tone_map_macros.svh"

module dmmtm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_mode,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_intensity,
    input logic [31:0] m_color_word
);

    `DMMTM_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `DMMTM_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_intensity), "stalled word changed")
    `DMMTM_ASSERT(a_color_rep, m_valid |-> m_color_word == {4{m_intensity}}, "color word mismatch")
    `DMMTM_ASSERT(a_gray_range, m_valid |-> (m_intensity == 8'd0 || m_intensity >= 8'd32), "gray level out of range")
    `DMMTM_ASSERT(a_scan_silent, s_valid && s_ready && !s_mode && !m_valid |=> !m_valid, "scan word gave result")

endmodule

bind depth_min_max_tone_map dmmtm_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_mode       (s_mode),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_intensity  (m_intensity),
    .m_color_word (m_color_word)
);
